@@ sv/psmooth_pkg.sv @@
// Package for the three-point polyline smoother.
// Holds sizes, divide-by-three constants, controller states and the
// command and tag structs shared by the controller and the datapath.
package psmooth_pkg;

   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 16;
   localparam int POINT_W    = 2 * COORD_W;
   localparam int SUM_W      = COORD_W + 2;
   localparam int MAG_W      = COORD_W + 1;
   localparam int PASS_W     = 8;

   localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_POINTS);
   localparam logic [PASS_W-1:0] PASS_RESET = PASS_W'(1);

   // floor(m / 3) == (m * RECIP3) >> RECIP_SHIFT for every m below 2**RECIP_SHIFT
   localparam int RECIP_SHIFT = MAG_W + 2;
   localparam int RECIP_W     = MAG_W + 1;
   localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
   localparam int PROD_W      = MAG_W + RECIP_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS_ISSUE,
      ST_PASS_DRAIN,
      ST_OUT_READ,
      ST_OUT_SEND
   } state_type;

   // Per-slot tag that rides the smoothing pipeline
   typedef struct packed {
      logic              valid;
      logic              emit;
      logic              has_prev;
      logic              has_next;
      logic [ADDR_W-1:0] dst_addr;
   } tag_type;

   typedef struct packed {
      logic              load_we;
      logic [ADDR_W-1:0] load_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              src_is_b;
      tag_type           slot;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } status_type;

endpackage

@@ sv/psmooth_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module psmooth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/psmooth_dp.sv @@
// Datapath of the polyline smoother: two point stores, the three-point
// window and the mean pipeline. Depends on psmooth_pkg and psmooth_ram.
module psmooth_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  psmooth_pkg::cmd_type                cmd,
   input  logic [psmooth_pkg::POINT_W-1:0]     load_point,
   output psmooth_pkg::status_type             status,
   output logic [psmooth_pkg::POINT_W-1:0]     rd_point
);

   localparam int CW = psmooth_pkg::COORD_W;

   logic                                   we_a;
   logic                                   we_b;
   logic [psmooth_pkg::ADDR_W-1:0]         waddr_a;
   logic [psmooth_pkg::POINT_W-1:0]        wdata_a;
   logic [psmooth_pkg::POINT_W-1:0]        rdata_a;
   logic [psmooth_pkg::POINT_W-1:0]        rdata_b;
   logic [psmooth_pkg::POINT_W-1:0]        res_point;

   psmooth_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;

   logic signed [CW-1:0] prev_x_ff, prev_y_ff, cur_x_ff, cur_y_ff, nxt_x_ff, nxt_y_ff;

   logic signed [psmooth_pkg::SUM_W-1:0] sum_x, sum_y;
   logic                                 neg_x_ff, neg_y_ff, neg_x4_ff, neg_y4_ff;
   logic [psmooth_pkg::MAG_W-1:0]        mag_x_ff, mag_y_ff;
   logic [psmooth_pkg::PROD_W-1:0]       prod_x, prod_y;
   logic [CW-1:0]                        q_x_ff, q_y_ff;
   logic [CW-1:0]                        res_x, res_y;

   // Store A takes loaded points and the output of passes reading store B
   assign we_a    = cmd.load_we | (tag4_ff.valid & tag4_ff.emit & cmd.src_is_b);
   assign we_b    = tag4_ff.valid & tag4_ff.emit & ~cmd.src_is_b;
   assign waddr_a = cmd.load_we ? cmd.load_addr : tag4_ff.dst_addr;
   assign wdata_a = cmd.load_we ? load_point : res_point;

   psmooth_ram #(
      .WIDTH (psmooth_pkg::POINT_W),
      .DEPTH (psmooth_pkg::MAX_POINTS)
   ) u_store_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr_a),
      .wdata (wdata_a),
      .re    (cmd.rd_en & ~cmd.src_is_b),
      .raddr (cmd.rd_addr),
      .rdata (rdata_a)
   );

   psmooth_ram #(
      .WIDTH (psmooth_pkg::POINT_W),
      .DEPTH (psmooth_pkg::MAX_POINTS)
   ) u_store_b (
      .clock (clock),
      .we    (we_b),
      .waddr (tag4_ff.dst_addr),
      .wdata (res_point),
      .re    (cmd.rd_en & cmd.src_is_b),
      .raddr (cmd.rd_addr),
      .rdata (rdata_b)
   );

   assign rd_point = cmd.src_is_b ? rdata_b : rdata_a;

   // Tag pipeline; stage 1 lines up with the RAM read latency
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag1_ff <= cmd.slot;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   assign status.pipe_busy = tag1_ff.valid | tag2_ff.valid | tag3_ff.valid | tag4_ff.valid;

   // Window shift: nxt is the point just read, cur the one being smoothed
   always_ff @(posedge clock) begin
      if (tag1_ff.valid) begin
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
         cur_x_ff  <= nxt_x_ff;
         cur_y_ff  <= nxt_y_ff;
         nxt_x_ff  <= rd_point[CW-1:0];
         nxt_y_ff  <= rd_point[2*CW-1:CW];
      end
   end

   always_comb begin
      sum_x = psmooth_pkg::SUM_W'(cur_x_ff);
      sum_y = psmooth_pkg::SUM_W'(cur_y_ff);
      if (tag2_ff.has_prev) begin
         sum_x = sum_x + psmooth_pkg::SUM_W'(prev_x_ff);
         sum_y = sum_y + psmooth_pkg::SUM_W'(prev_y_ff);
      end
      if (tag2_ff.has_next) begin
         sum_x = sum_x + psmooth_pkg::SUM_W'(nxt_x_ff);
         sum_y = sum_y + psmooth_pkg::SUM_W'(nxt_y_ff);
      end
   end

   // Sign and magnitude, so the divide truncates toward zero
   always_ff @(posedge clock) begin
      neg_x_ff <= sum_x[psmooth_pkg::SUM_W-1];
      neg_y_ff <= sum_y[psmooth_pkg::SUM_W-1];
      mag_x_ff <= psmooth_pkg::MAG_W'(sum_x[psmooth_pkg::SUM_W-1] ? -sum_x : sum_x);
      mag_y_ff <= psmooth_pkg::MAG_W'(sum_y[psmooth_pkg::SUM_W-1] ? -sum_y : sum_y);
   end

   assign prod_x = psmooth_pkg::PROD_W'(mag_x_ff) * psmooth_pkg::PROD_W'(psmooth_pkg::RECIP3);
   assign prod_y = psmooth_pkg::PROD_W'(mag_y_ff) * psmooth_pkg::PROD_W'(psmooth_pkg::RECIP3);

   // Interior points divide by three, end points by two
   always_ff @(posedge clock) begin
      neg_x4_ff <= neg_x_ff;
      neg_y4_ff <= neg_y_ff;
      if (tag3_ff.has_prev & tag3_ff.has_next) begin
         q_x_ff <= prod_x[psmooth_pkg::RECIP_SHIFT +: CW];
         q_y_ff <= prod_y[psmooth_pkg::RECIP_SHIFT +: CW];
      end else begin
         q_x_ff <= mag_x_ff[psmooth_pkg::MAG_W-1:1];
         q_y_ff <= mag_y_ff[psmooth_pkg::MAG_W-1:1];
      end
   end

   assign res_x     = neg_x4_ff ? -q_x_ff : q_x_ff;
   assign res_y     = neg_y4_ff ? -q_y_ff : q_y_ff;
   assign res_point = {res_y, res_x};

endmodule

@@ sv/psmooth_ctrl.sv @@
// Controller of the polyline smoother: load, pass sequencing, drain and
// result send. Depends on psmooth_pkg.
module psmooth_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [psmooth_pkg::PASS_W-1:0]    csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tlast,
   output logic                              rsp_dropped,
   output psmooth_pkg::cmd_type              cmd,
   input  psmooth_pkg::status_type           status
);

   localparam int AW = psmooth_pkg::ADDR_W;
   localparam int NW = psmooth_pkg::CNT_W;

   psmooth_pkg::state_type state_ff, state_in;

   logic [psmooth_pkg::PASS_W-1:0] pass_count_ff, pass_left_ff, pass_left_in;
   logic [NW-1:0]                  total_ff, total_in, slot_ff, slot_in;
   logic                           overflow_ff, overflow_in, src_b_ff, src_b_in;
   logic [AW-1:0]                  out_idx_ff, out_idx_in;
   logic                           has_room;
   logic [NW-1:0]                  total_new;
   logic                           out_is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= psmooth_pkg::ST_LOAD;
         pass_count_ff <= psmooth_pkg::PASS_RESET;
         pass_left_ff  <= '0;
         total_ff      <= '0;
         slot_ff       <= '0;
         overflow_ff   <= 1'b0;
         src_b_ff      <= 1'b0;
         out_idx_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         pass_left_ff  <= pass_left_in;
         total_ff      <= total_in;
         slot_ff       <= slot_in;
         overflow_ff   <= overflow_in;
         src_b_ff      <= src_b_in;
         out_idx_ff    <= out_idx_in;
         if (csr_wr_en) begin
            pass_count_ff <= csr_wr_data;
         end
      end
   end

   assign has_room    = total_ff < psmooth_pkg::MAX_CNT;
   assign total_new   = has_room ? total_ff + NW'(1) : total_ff;
   assign out_is_last = (NW'(out_idx_ff) + NW'(1)) == total_ff;

   assign rsp_tlast   = out_is_last;
   assign rsp_dropped = overflow_ff;

   always_comb begin
      state_in     = state_ff;
      pass_left_in = pass_left_ff;
      total_in     = total_ff;
      slot_in      = slot_ff;
      overflow_in  = overflow_ff;
      src_b_in     = src_b_ff;
      out_idx_in   = out_idx_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      cmd          = '0;
      cmd.src_is_b = src_b_ff;
      cmd.load_addr = total_ff[AW-1:0];

      case (state_ff)
         psmooth_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_we = has_room;
               total_in    = total_new;
               overflow_in = overflow_ff | ~has_room;
               if (req_tlast) begin
                  if (total_new > NW'(2) && pass_count_ff != '0) begin
                     state_in     = psmooth_pkg::ST_PASS_ISSUE;
                     pass_left_in = pass_count_ff;
                     slot_in      = '0;
                     src_b_in     = 1'b0;
                  end else begin
                     total_in    = '0;
                     overflow_in = 1'b0;
                  end
               end
            end
         end

         // One slot per cycle; the extra slot at the end flushes the window
         psmooth_pkg::ST_PASS_ISSUE: begin
            cmd.rd_en              = slot_ff != total_ff;
            cmd.rd_addr            = slot_ff[AW-1:0];
            cmd.slot.valid         = 1'b1;
            cmd.slot.emit          = slot_ff != '0;
            cmd.slot.has_prev      = slot_ff >= NW'(2);
            cmd.slot.has_next      = slot_ff != total_ff;
            cmd.slot.dst_addr      = AW'(slot_ff - NW'(1));
            if (slot_ff == total_ff) begin
               state_in = psmooth_pkg::ST_PASS_DRAIN;
            end else begin
               slot_in = slot_ff + NW'(1);
            end
         end

         psmooth_pkg::ST_PASS_DRAIN: begin
            if (!status.pipe_busy) begin
               src_b_in     = ~src_b_ff;
               pass_left_in = pass_left_ff - psmooth_pkg::PASS_W'(1);
               slot_in      = '0;
               out_idx_in   = '0;
               if (pass_left_ff == psmooth_pkg::PASS_W'(1)) begin
                  state_in = psmooth_pkg::ST_OUT_READ;
               end else begin
                  state_in = psmooth_pkg::ST_PASS_ISSUE;
               end
            end
         end

         psmooth_pkg::ST_OUT_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = out_idx_ff;
            state_in    = psmooth_pkg::ST_OUT_SEND;
         end

         // Read data stays put in the RAM output register while stalled
         psmooth_pkg::ST_OUT_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (out_is_last) begin
                  state_in    = psmooth_pkg::ST_LOAD;
                  total_in    = '0;
                  overflow_in = 1'b0;
               end else begin
                  out_idx_in = out_idx_ff + AW'(1);
                  state_in   = psmooth_pkg::ST_OUT_READ;
               end
            end
         end

         default: begin
            state_in = psmooth_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

@@ sv/polyline_three_point_smoother_top.sv @@
// Top level of the three-point polyline smoother.
// Depends on psmooth_pkg, psmooth_ctrl, psmooth_dp and psmooth_ram.
//
// Usage:
//  - req channel: one path point per transaction, req_tlast on the final point.
//    Points are accepted one per cycle while the block is loading. Points past
//    64 stored are discarded and the path's results carry rsp_tuser = 1.
//  - The final point starts pass_count smoothing passes (csr_wr_en/csr_wr_data,
//    reset value 1). Each pass streams the point store plus a flush slot
//    through the three-point window, then waits for the mean pipeline to
//    drain, since each pass reads what the previous one wrote.
//  - rsp channel: n smoothed points, rsp_tlast on the last. Each result is
//    read from the store, then sent. If rsp_tready is low the result holds
//    in the store's read register until taken.
//  - A path of two or fewer points, or pass_count 0, yields no transaction.
//  - req_tready is low from the final point until the last result is taken.
//  - Reset (synchronous, active high) returns to loading with an empty path
//    and pass_count 1; point store contents are not cleared.
module polyline_three_point_smoother_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // pass_count
   // input points
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [15:0] point_x, [31:16] point_y
   input  logic        req_tlast,     // is_final_point
   // smoothed points
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [15:0] out_x, [31:16] out_y
   output logic        rsp_tlast,     // out_last
   output logic [0:0]  rsp_tuser      // [0] dropped_points
);

   psmooth_pkg::cmd_type    cmd;
   psmooth_pkg::status_type status;
   logic                    dropped;

   psmooth_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .rsp_dropped (dropped),
      .cmd         (cmd),
      .status      (status)
   );

   psmooth_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_point (req_tdata),
      .status     (status),
      .rd_point   (rsp_tdata)
   );

   assign rsp_tuser[0] = dropped;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for polyline_three_point_smoother_top.
// Directed table, store-full paths and random paths, checked against an in-bench smoothing model or typed-in results.
// Depends on psmooth_pkg and the smoother RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL_ITEMS = 280;

   typedef enum logic {ROW_POINT, ROW_PASSES} row_kind_type;
   typedef enum int {STY_UNIFORM, STY_EXTREME, STY_SMALL} coord_style_type;

   // one row of the directed table; for ROW_PASSES x carries the pass count
   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  x;
      logic [15:0]  y;
      logic         fin;
      logic         typed;    // results typed in below instead of modeled
      logic [6:0]   gold_n;
      logic [15:0]  gold_x;
      logic [15:0]  gold_y;
   } stim_row_type;

   typedef struct packed {
      logic [psmooth_pkg::COORD_W-1:0] x;
      logic [psmooth_pkg::COORD_W-1:0] y;
      logic                            last;
      logic                            dropped;
   } smooth_pt_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           csr_wr_en   = 1'b0;
   logic [psmooth_pkg::PASS_W-1:0] csr_wr_data = '0;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [31:0]                    req_tdata   = '0;
   logic                           req_tlast   = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [31:0]                    rsp_tdata;
   logic                           rsp_tlast;
   logic [0:0]                     rsp_tuser;

   // typed-in expectation riding along with the point being offered
   logic        gold_on = 1'b0;
   logic [6:0]  gold_n  = '0;
   logic [15:0] gold_x  = '0;
   logic [15:0] gold_y  = '0;

   // smoothing model state
   int                             path_x [psmooth_pkg::MAX_POINTS];
   int                             path_y [psmooth_pkg::MAX_POINTS];
   int                             pts_cnt;
   logic                           drop_seen;
   logic [psmooth_pkg::PASS_W-1:0] pass_cfg;
   int                             last_path_n      = 0;
   logic                           last_path_silent = 1'b0;

   smooth_pt_type expected_q [$];
   smooth_pt_type model_out [$];

   int   err_count  = 0;
   int   items_sent = 0;
   logic calm       = 1'b0;

   stim_row_type directed_tab [0:26] = '{
      // constant paths: every mean equals the constant
      '{ROW_POINT,  16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 7'd3, 16'h7FFF, 16'h7FFF},
      '{ROW_POINT,  16'h8000, 16'h8000, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h8000, 16'h8000, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h8000, 16'h8000, 1'b1, 1'b1, 7'd3, 16'h8000, 16'h8000},
      // two-point and one-point paths are silent
      '{ROW_POINT,  16'h0001, 16'hFFFF, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h0005, 16'h0007, 1'b1, 1'b1, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h0064, 16'h00C8, 1'b1, 1'b1, 7'd0, 16'h0000, 16'h0000},
      // alternating extremes
      '{ROW_POINT,  16'h7FFF, 16'h8000, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h8000, 16'h7FFF, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h7FFF, 16'h8000, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'hFFFF, 16'h0001, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h0000, 16'h0000, 1'b1, 1'b0, 7'd0, 16'h0000, 16'h0000},
      // negative sums: truncation toward zero differs from floor
      '{ROW_POINT,  16'hFFFF, 16'h0001, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'hFFFE, 16'h0002, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h0000, 16'h0000, 1'b1, 1'b0, 7'd0, 16'h0000, 16'h0000},
      // zero passes: silent, path still cleared
      '{ROW_PASSES, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h0007, 16'h0008, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h0009, 16'h000A, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h000B, 16'h000C, 1'b1, 1'b1, 7'd0, 16'h0000, 16'h0000},
      // max passes on a short path
      '{ROW_PASSES, 16'h00FF, 16'h0000, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h1234, 16'h8000, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h7FFF, 16'hFFFB, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h8001, 16'h0003, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_POINT,  16'h4000, 16'h7FFF, 1'b1, 1'b0, 7'd0, 16'h0000, 16'h0000},
      '{ROW_PASSES, 16'h0002, 16'h0000, 1'b0, 1'b0, 7'd0, 16'h0000, 16'h0000}
   };

   polyline_three_point_smoother_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------- smoothing model ----------------

   function automatic void smooth_path();
      int            nx [psmooth_pkg::MAX_POINTS];
      int            ny [psmooth_pkg::MAX_POINTS];
      int            sx;
      int            sy;
      int            d;
      smooth_pt_type pt;
      for (int p = 0; p < int'(pass_cfg); p++) begin
         for (int j = 0; j < pts_cnt; j++) begin
            sx = path_x[j];
            sy = path_y[j];
            d  = 1;
            if (j > 0) begin
               sx += path_x[j-1];
               sy += path_y[j-1];
               d++;
            end
            if (j + 1 < pts_cnt) begin
               sx += path_x[j+1];
               sy += path_y[j+1];
               d++;
            end
            // int division truncates toward zero
            nx[j] = sx / d;
            ny[j] = sy / d;
         end
         for (int j = 0; j < pts_cnt; j++) begin
            path_x[j] = nx[j];
            path_y[j] = ny[j];
         end
      end
      for (int k = 0; k < pts_cnt; k++) begin
         pt.x       = psmooth_pkg::COORD_W'(path_x[k]);
         pt.y       = psmooth_pkg::COORD_W'(path_y[k]);
         pt.last    = (k + 1 == pts_cnt);
         pt.dropped = drop_seen;
         model_out  = {model_out, pt};
      end
   endfunction

   function automatic void absorb_point(input logic [15:0] px, input logic [15:0] py,
                                        input logic fin);
      if (pts_cnt < psmooth_pkg::MAX_POINTS) begin
         path_x[pts_cnt] = int'($signed(px));
         path_y[pts_cnt] = int'($signed(py));
         pts_cnt++;
      end else begin
         drop_seen = 1'b1;
      end
      if (!fin) return;
      last_path_n      = pts_cnt;
      last_path_silent = 1'b1;
      if (pts_cnt > 2 && pass_cfg != 0) begin
         smooth_path();
         last_path_silent = 1'b0;
      end
      pts_cnt   = 0;
      drop_seen = 1'b0;
   endfunction

   // ---------------- checking ----------------

   task automatic report(input string what);
      err_count++;
      $display("tb_top: mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic take_point();
      smooth_pt_type pt;
      absorb_point(req_tdata[15:0], req_tdata[31:16], req_tlast);
      if (gold_on) begin
         model_out.delete();
         for (int k = 0; k < int'(gold_n); k++) begin
            pt.x       = gold_x;
            pt.y       = gold_y;
            pt.last    = (k + 1 == int'(gold_n));
            pt.dropped = 1'b0;
            expected_q = {expected_q, pt};
         end
      end else begin
         expected_q = {expected_q, model_out};
         model_out.delete();
      end
   endtask

   task automatic check_result();
      smooth_pt_type pt;
      if (expected_q.size() == 0) begin
         report($sformatf("unexpected result data=%h last=%b user=%b",
                          rsp_tdata, rsp_tlast, rsp_tuser));
      end else begin
         pt = expected_q.pop_front();
         if (rsp_tdata[15:0] !== pt.x)
            report($sformatf("out_x %h, want %h", rsp_tdata[15:0], pt.x));
         if (rsp_tdata[31:16] !== pt.y)
            report($sformatf("out_y %h, want %h", rsp_tdata[31:16], pt.y));
         if (rsp_tlast !== pt.last)
            report($sformatf("out_last %b, want %b", rsp_tlast, pt.last));
         if (rsp_tuser[0] !== pt.dropped)
            report($sformatf("dropped_points %b, want %b", rsp_tuser[0], pt.dropped));
      end
   endtask

   // samples pre-edge values at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         pts_cnt   = 0;
         drop_seen = 1'b0;
         pass_cfg  = psmooth_pkg::PASS_RESET;
         expected_q.delete();
      end else begin
         if (csr_wr_en) pass_cfg = csr_wr_data;
         if (req_tvalid && req_tready) take_point();
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   // ---------------- driving ----------------

   function automatic bit take_gap();
      return !calm && ($urandom_range(99) < 8);
   endfunction

   always @(negedge clock) rsp_tready <= !take_gap();

   task automatic send_point(input logic [15:0] px, input logic [15:0] py, input logic fin,
                             input logic typed, input logic [6:0] gn,
                             input logic [15:0] gx, input logic [15:0] gy);
      @(negedge clock);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      req_tlast  <= fin;
      gold_on    <= typed;
      gold_n     <= gn;
      gold_x     <= gx;
      gold_y     <= gy;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // block idle: all results in, plus a pause, longer when the last path was silent
   task automatic settle();
      int pause;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      pause = last_path_silent ? int'(pass_cfg) * (last_path_n + 8) + 16 : 4;
      repeat (pause) @(negedge clock);
   endtask

   task automatic set_passes(input logic [psmooth_pkg::PASS_W-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [15:0] pick_coord(input coord_style_type style);
      case (style)
         STY_UNIFORM: return 16'($urandom);
         STY_EXTREME: begin
            case ($urandom_range(3))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               2:       return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default: return 16'(int'($urandom_range(8)) - 4);
      endcase
   endfunction

   task automatic run_path(input int n, input coord_style_type style);
      for (int k = 0; k < n; k++)
         send_point(pick_coord(style), pick_coord(style), k == n - 1,
                    1'b0, 7'd0, 16'h0, 16'h0);
   endtask

   // ---------------- stimulus ----------------

   initial begin
      int              path_no;
      int              r;
      int              n;
      int              passes_now;
      coord_style_type style;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_tab[i]) begin
         if (directed_tab[i].kind == ROW_PASSES)
            set_passes(directed_tab[i].x[psmooth_pkg::PASS_W-1:0]);
         else
            send_point(directed_tab[i].x, directed_tab[i].y, directed_tab[i].fin,
                       directed_tab[i].typed, directed_tab[i].gold_n,
                       directed_tab[i].gold_x, directed_tab[i].gold_y);
      end
      passes_now = 2;

      // store full: final point itself dropped, then exactly full
      run_path(psmooth_pkg::MAX_POINTS + 2, STY_UNIFORM);
      run_path(psmooth_pkg::MAX_POINTS, STY_SMALL);

      path_no = 0;
      while (items_sent < TOTAL_ITEMS) begin
         calm = (path_no >= 2 && path_no < 7);
         if (path_no % 4 == 0) begin
            r = $urandom_range(99);
            if (r < 10)      passes_now = 0;
            else if (r < 16) passes_now = 255;
            else if (r < 24) passes_now = $urandom_range(255, 7);
            else             passes_now = $urandom_range(6, 1);
            set_passes(psmooth_pkg::PASS_W'(passes_now));
         end
         r = $urandom_range(99);
         if (r < 6)
            n = $urandom_range(2, 1);
         else if (r < 12 && passes_now < 7)
            n = $urandom_range(psmooth_pkg::MAX_POINTS + 4, psmooth_pkg::MAX_POINTS - 1);
         else
            n = $urandom_range(16, 3);
         r = $urandom_range(9);
         style = (r < 6) ? STY_UNIFORM : (r < 8) ? STY_SMALL : STY_EXTREME;
         run_path(n, style);
         path_no++;
      end
      calm = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      // catch anything emitted late
      repeat (64) @(posedge clock);
      if (err_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
